[hw/rtl/hbridge_motor_protect_controller_top_defines.svh]
// Assertion macros for the H-bridge motor protection controller.
// Included by files that carry concurrent checks; needs clock and reset in scope.
`ifndef HBRIDGE_MOTOR_PROTECT_CONTROLLER_TOP_DEFINES_SVH
`define HBRIDGE_MOTOR_PROTECT_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HMPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hmpc check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HMPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hmpc check failed");

`endif

[hw/rtl/hmpc_pkg.sv]
// Shared types, codes and constants for the H-bridge motor protection controller.
// No dependencies; imported by every module of the block.
package hmpc_pkg;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_FORWARD   = 3'd1;
   localparam logic [2:0] OP_REVERSE   = 3'd2;
   localparam logic [2:0] OP_STOP      = 3'd3;
   localparam logic [2:0] OP_CLEAR_OC  = 3'd4;
   localparam logic [2:0] OP_CLEAR_EMR = 3'd5;

   localparam logic [2:0] MODE_STOP = 3'd0;
   localparam logic [2:0] MODE_FWD  = 3'd1;
   localparam logic [2:0] MODE_REV  = 3'd2;
   localparam logic [2:0] MODE_OVER = 3'd3;
   localparam logic [2:0] MODE_EMER = 3'd4;

   localparam logic [2:0] CSR_RUN_SPEED     = 3'd0;
   localparam logic [2:0] CSR_START_DUTY    = 3'd1;
   localparam logic [2:0] CSR_RAMP_STEP     = 3'd2;
   localparam logic [2:0] CSR_RAMP_INTERVAL = 3'd3;
   localparam logic [2:0] CSR_DEAD_TIME     = 3'd4;
   localparam logic [2:0] CSR_SENSOR_OFFSET = 3'd5;
   localparam logic [2:0] CSR_CURRENT_LIMIT = 3'd6;
   localparam logic [2:0] CSR_OC_HOLD       = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int START_WINDOW_MS_DEF = 500;
   localparam int TRIP_LIMIT_DEF      = 3;

   localparam logic [2:0]  DIAG_CONFIRM_MS = 3'd6;
   localparam logic [3:0]  CHECK_PERIOD_MS = 4'd10;
   localparam logic [15:0] TRIP_WINDOW_MS  = 16'd60000;

   typedef struct packed {
      logic [7:0]  run_speed;
      logic [7:0]  start_duty;
      logic [7:0]  ramp_step;
      logic [15:0] ramp_interval_ms;
      logic [15:0] dead_time_ms;
      logic [11:0] sensor_offset;
      logic [11:0] current_limit;
      logic [15:0] overcurrent_hold_ms;
   } hmpc_cfg_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic        diag_level;
      logic [11:0] current_sample;
   } hmpc_req_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       drive_a;
      logic       drive_b;
      logic [2:0] motor_state;
      logic       fault_led;
      logic       hard_fault;
      logic       emergency_active;
   } hmpc_rsp_type;

endpackage

[hw/rtl/hmpc_req_if.sv]
// Command channel: one word per 1 ms tick or command, with diag level and current sample.
// No dependencies.
interface hmpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic        diag_level;
   logic [11:0] current_sample;

   modport source (output valid, output operation, output diag_level,
                   output current_sample, input ready);
   modport sink   (input valid, input operation, input diag_level,
                   input current_sample, output ready);
endinterface

[hw/rtl/hmpc_rsp_if.sv]
// Result channel: bridge drive, duty and fault status, one word per command word.
// No dependencies.
interface hmpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pwm_duty;
   logic       drive_a;
   logic       drive_b;
   logic [2:0] motor_state;
   logic       fault_led;
   logic       hard_fault;
   logic       emergency_active;

   modport source (output valid, output pwm_duty, output drive_a, output drive_b,
                   output motor_state, output fault_led, output hard_fault,
                   output emergency_active, input ready);
   modport sink   (input valid, input pwm_duty, input drive_a, input drive_b,
                   input motor_state, input fault_led, input hard_fault,
                   input emergency_active, output ready);
endinterface

[hw/rtl/hmpc_csr.sv]
// Configuration register file of the motor protection controller.
// Depends on hmpc_pkg.
module hmpc_csr
   import hmpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output hmpc_cfg_type           cfg
);

   hmpc_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RUN_SPEED:     cfg_in.run_speed           = csr_wdata[7:0];
            CSR_START_DUTY:    cfg_in.start_duty          = csr_wdata[7:0];
            CSR_RAMP_STEP:     cfg_in.ramp_step           = csr_wdata[7:0];
            CSR_RAMP_INTERVAL: cfg_in.ramp_interval_ms    = csr_wdata;
            CSR_DEAD_TIME:     cfg_in.dead_time_ms        = csr_wdata;
            CSR_SENSOR_OFFSET: cfg_in.sensor_offset       = csr_wdata[11:0];
            CSR_CURRENT_LIMIT: cfg_in.current_limit       = csr_wdata[11:0];
            CSR_OC_HOLD:       cfg_in.overcurrent_hold_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_speed           <= 8'd255;
         cfg_ff.start_duty          <= 8'd64;
         cfg_ff.ramp_step           <= 8'd8;
         cfg_ff.ramp_interval_ms    <= 16'd20;
         cfg_ff.dead_time_ms        <= 16'd100;
         cfg_ff.sensor_offset       <= 12'd0;
         cfg_ff.current_limit       <= 12'd1000;
         cfg_ff.overcurrent_hold_ms <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/hmpc_core.sv]
// Control state and per-word update: direction, dead time, soft start, diag and overcurrent.
// Depends on hmpc_pkg; stepped by the top level once per command word.
module hmpc_core
   import hmpc_pkg::*;
#(
   parameter int START_WINDOW_MS = START_WINDOW_MS_DEF,
   parameter int TRIP_LIMIT      = TRIP_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  hmpc_req_type item,
   input  hmpc_cfg_type cfg,
   output hmpc_rsp_type result
);

   localparam logic [15:0] START_WINDOW = 16'(START_WINDOW_MS);
   localparam logic [2:0]  TRIP_MAX     = 3'(TRIP_LIMIT);

   typedef struct packed {
      logic [2:0]  mode_now;
      logic [1:0]  mode_wanted;
      logic        emergency_flag;
      logic        pwm_gated;
      logic [7:0]  duty_now;
      logic [2:0]  diag_low_ms;
      logic [15:0] dead_elapsed_ms;
      logic        dead_wait;
      logic [15:0] ramp_elapsed_ms;
      logic [15:0] run_elapsed_ms;
      logic [3:0]  check_elapsed_ms;
      logic [15:0] over_elapsed_ms;
      logic        over_active;
      logic [15:0] window_elapsed_ms;
      logic        window_active;
      logic [2:0]  trip_count;
      logic        hard_fault_latch;
      logic        led_on;
   } hmpc_state_type;

   hmpc_state_type st_ff, st_in;

   always_comb begin
      logic        diag_t;
      logic        tick_done;
      logic [2:0]  dir;
      logic [2:0]  opposite;
      logic [8:0]  sum;
      logic [11:0] net;
      logic [13:0] lhs;
      logic [13:0] rhs;
      logic        running;
      logic        live;

      st_in     = st_ff;
      diag_t    = item.diag_level;
      tick_done = 1'b0;
      dir       = MODE_FWD;
      opposite  = MODE_REV;
      sum       = '0;
      net       = '0;
      lhs       = '0;
      rhs       = '0;

      // diag line is sampled on every word unless it is driving the LED
      if (!item.diag_level && !st_ff.led_on) begin
         st_in.emergency_flag = 1'b1;
         st_in.pwm_gated      = 1'b1;
      end

      unique case (item.operation)
         OP_TICK: begin
            if (st_in.dead_elapsed_ms != '1)   st_in.dead_elapsed_ms   += 16'd1;
            if (st_in.ramp_elapsed_ms != '1)   st_in.ramp_elapsed_ms   += 16'd1;
            if (st_in.run_elapsed_ms != '1)    st_in.run_elapsed_ms    += 16'd1;
            if (st_in.check_elapsed_ms != '1)  st_in.check_elapsed_ms  += 4'd1;
            if (st_in.over_elapsed_ms != '1)   st_in.over_elapsed_ms   += 16'd1;
            if (st_in.window_elapsed_ms != '1) st_in.window_elapsed_ms += 16'd1;

            if (st_in.led_on) diag_t = 1'b0;
            if (st_in.emergency_flag) begin
               if (diag_t) begin
                  st_in.emergency_flag = 1'b0;
                  st_in.diag_low_ms    = '0;
               end else if (st_in.diag_low_ms == '0) begin
                  st_in.diag_low_ms = 3'd1;
               end else begin
                  if (st_in.diag_low_ms != '1) st_in.diag_low_ms += 3'd1;
                  // confirm the emergency and end this tick
                  if (st_in.diag_low_ms >= DIAG_CONFIRM_MS && st_in.mode_now != MODE_EMER) begin
                     st_in.mode_now = MODE_EMER;
                     tick_done      = 1'b1;
                  end
               end
            end else begin
               st_in.diag_low_ms = '0;
            end

            if (!tick_done) begin
               if (st_in.mode_wanted != MODE_STOP[1:0] &&
                   st_in.mode_now != {1'b0, st_in.mode_wanted}) begin
                  if (!st_in.dead_wait || st_in.dead_elapsed_ms >= cfg.dead_time_ms) begin
                     st_in.run_elapsed_ms  = '0;
                     st_in.over_active     = 1'b0;
                     st_in.mode_now        = {1'b0, st_in.mode_wanted};
                     st_in.duty_now        = cfg.start_duty;
                     st_in.ramp_elapsed_ms = '0;
                  end
               end else if (st_in.mode_now == MODE_FWD || st_in.mode_now == MODE_REV) begin
                  if (st_in.duty_now < cfg.run_speed &&
                      st_in.ramp_elapsed_ms >= cfg.ramp_interval_ms) begin
                     st_in.ramp_elapsed_ms = '0;
                     sum = {1'b0, st_in.duty_now} + {1'b0, cfg.ramp_step};
                     st_in.duty_now = (sum < {1'b0, cfg.run_speed}) ? sum[7:0] : cfg.run_speed;
                  end

                  if (st_in.check_elapsed_ms >= CHECK_PERIOD_MS) begin
                     st_in.check_elapsed_ms = '0;
                     net = (item.current_sample > cfg.sensor_offset) ?
                           item.current_sample - cfg.sensor_offset : '0;
                     // start window: compare 2*net against 3*limit
                     if (st_in.run_elapsed_ms < START_WINDOW) begin
                        lhs = {1'b0, net, 1'b0};
                        rhs = 14'(cfg.current_limit) * 14'd3;
                     end else begin
                        lhs = {2'b00, net};
                        rhs = {2'b00, cfg.current_limit};
                     end
                     if (lhs < rhs) begin
                        st_in.over_active = 1'b0;
                     end else if (!st_in.over_active) begin
                        st_in.over_active     = 1'b1;
                        st_in.over_elapsed_ms = '0;
                     end else if (st_in.over_elapsed_ms >= cfg.overcurrent_hold_ms) begin
                        st_in.mode_now    = MODE_OVER;
                        st_in.mode_wanted = MODE_STOP[1:0];
                        st_in.duty_now    = '0;
                        st_in.led_on      = 1'b1;
                        if (!st_in.window_active ||
                            st_in.window_elapsed_ms > TRIP_WINDOW_MS) begin
                           st_in.window_active     = 1'b1;
                           st_in.window_elapsed_ms = '0;
                           st_in.trip_count        = 3'd1;
                        end else if (st_in.trip_count != '1) begin
                           st_in.trip_count += 3'd1;
                        end
                        if (st_in.trip_count > TRIP_MAX) st_in.hard_fault_latch = 1'b1;
                     end
                  end
               end
            end
         end

         OP_FORWARD, OP_REVERSE: begin
            if (item.operation == OP_REVERSE) begin
               dir      = MODE_REV;
               opposite = MODE_FWD;
            end
            if (st_in.mode_wanted != dir[1:0] &&
                st_in.mode_now != MODE_OVER && !st_in.emergency_flag) begin
               if (st_in.mode_now == opposite) begin
                  // halt the bridge before the reversal and start the dead time
                  st_in.duty_now        = '0;
                  st_in.mode_now        = MODE_STOP;
                  st_in.dead_wait       = 1'b1;
                  st_in.dead_elapsed_ms = '0;
               end else begin
                  st_in.dead_wait = 1'b0;
               end
               st_in.mode_wanted = dir[1:0];
            end
         end

         OP_STOP: begin
            st_in.duty_now    = '0;
            st_in.mode_wanted = MODE_STOP[1:0];
            if (st_in.emergency_flag)           st_in.mode_now = MODE_EMER;
            else if (st_in.mode_now != MODE_OVER) st_in.mode_now = MODE_STOP;
         end

         OP_CLEAR_OC: begin
            if (!st_in.hard_fault_latch && !st_in.emergency_flag &&
                st_in.mode_now == MODE_OVER) begin
               st_in.led_on      = 1'b0;
               st_in.mode_now    = MODE_STOP;
               st_in.over_active = 1'b0;
            end
         end

         OP_CLEAR_EMR: begin
            st_in.led_on = 1'b0;
            if (item.diag_level && !st_in.hard_fault_latch) begin
               st_in.emergency_flag = 1'b0;
               st_in.pwm_gated      = 1'b0;
               if (st_in.mode_now == MODE_EMER) st_in.mode_now = MODE_STOP;
            end
         end

         default: st_in = st_in;
      endcase

      running = (st_in.mode_now == MODE_FWD) || (st_in.mode_now == MODE_REV);
      live    = running && !st_in.pwm_gated;
      result.pwm_duty         = live ? st_in.duty_now : '0;
      result.drive_a          = live && (st_in.mode_now == MODE_FWD);
      result.drive_b          = live && (st_in.mode_now == MODE_REV);
      result.motor_state      = st_in.mode_now;
      result.fault_led        = st_in.led_on;
      result.hard_fault       = st_in.hard_fault_latch;
      result.emergency_active = st_in.emergency_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

endmodule

[hw/rtl/hbridge_motor_protect_controller_top.sv]
// H-bridge motor protection controller, top level. Depends on hmpc_pkg, hmpc_req_if,
// hmpc_rsp_if, hmpc_csr, hmpc_core and the assertion macro header.
//
// Each command word (1 ms tick or command, diag level, current sample) is registered in the
// input register and yields exactly one result word: the control update in hmpc_core then
// writes the output register. The rate is one word per cycle while the result channel is
// drained; while a result waits in the
// output register the input register takes one more word and then holds it until the
// result is drained. Configuration writes take effect on the next clock and are meant to
// be made while no word is in flight.
module hbridge_motor_protect_controller_top
   import hmpc_pkg::*;
#(
   parameter int START_WINDOW_MS = START_WINDOW_MS_DEF,
   parameter int TRIP_LIMIT      = TRIP_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   hmpc_req_if.sink               req_ch,
   hmpc_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "hbridge_motor_protect_controller_top_defines.svh"

   hmpc_cfg_type cfg;
   hmpc_req_type in_data_ff;
   hmpc_rsp_type out_data_ff;
   hmpc_rsp_type result;
   logic         in_valid_ff;
   logic         out_valid_ff;
   logic         advance;

   hmpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hmpc_core #(
      .START_WINDOW_MS (START_WINDOW_MS),
      .TRIP_LIMIT      (TRIP_LIMIT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // advance the held word whenever the output register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         if (advance)           out_valid_ff <= 1'b1;
         else if (rsp_ch.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff.operation      <= req_ch.operation;
         in_data_ff.diag_level     <= req_ch.diag_level;
         in_data_ff.current_sample <= req_ch.current_sample;
      end
      if (advance) out_data_ff <= result;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.pwm_duty         = out_data_ff.pwm_duty;
   assign rsp_ch.drive_a          = out_data_ff.drive_a;
   assign rsp_ch.drive_b          = out_data_ff.drive_b;
   assign rsp_ch.motor_state      = out_data_ff.motor_state;
   assign rsp_ch.fault_led        = out_data_ff.fault_led;
   assign rsp_ch.hard_fault       = out_data_ff.hard_fault;
   assign rsp_ch.emergency_active = out_data_ff.emergency_active;

   `HMPC_ASSERT_NOW(a_bridge_exclusive, out_valid_ff, !(out_data_ff.drive_a && out_data_ff.drive_b))
   `HMPC_ASSERT_NOW(a_duty_needs_drive, out_valid_ff && out_data_ff.pwm_duty != 8'd0,
                    out_data_ff.drive_a || out_data_ff.drive_b)
   `HMPC_ASSERT_NEXT(a_step_loads_output, advance, out_valid_ff)
   `HMPC_ASSERT_NEXT(a_stalled_word_held, in_valid_ff && !advance,
                     in_valid_ff && $stable(in_data_ff))

endmodule

[tb/tb_hbridge_motor_protect_controller_top.sv]
// Self-checking bench for the H-bridge motor protection controller top level.
// Needs hmpc_pkg, hmpc_req_if, hmpc_rsp_if and the RTL; predicts every status word
// from its own copy of the bridge state and compares it field by field.
module tb_hbridge_motor_protect_controller_top;
   import hmpc_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hmpc_req_if req_ch ();
   hmpc_rsp_if rsp_ch ();

   hbridge_motor_protect_controller_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bridge state as the block should hold it
   hmpc_cfg_type cfg;
   logic [2:0]   st_mode, st_wanted, st_diag_low, st_trips;
   logic         st_emergency, st_gated, st_hard, st_led;
   logic         st_dead_wait, st_over_on, st_window_on;
   logic [7:0]   st_duty;
   logic [15:0]  st_dead_ms, st_ramp_ms, st_run_ms, st_over_ms, st_window_ms;
   logic [3:0]   st_check_ms;

   hmpc_rsp_type expected_status[$];
   int           error_count = 0;
   int unsigned  cycle_count = 0;
   logic         quiet = 1'b0;
   int           diag_low_left = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hbridge_motor_protect_controller_top: mismatch");
         $finish;
      end
   end

   function automatic void clear_model();
      cfg = '{run_speed: 8'd255, start_duty: 8'd64, ramp_step: 8'd8,
              ramp_interval_ms: 16'd20, dead_time_ms: 16'd100, sensor_offset: 12'd0,
              current_limit: 12'd1000, overcurrent_hold_ms: 16'd100};
      st_mode = MODE_STOP;
      st_wanted = MODE_STOP;
      st_diag_low = '0;
      st_trips = '0;
      {st_emergency, st_gated, st_hard, st_led} = '0;
      {st_dead_wait, st_over_on, st_window_on} = '0;
      st_duty = '0;
      {st_dead_ms, st_ramp_ms, st_run_ms, st_over_ms, st_window_ms} = '0;
      st_check_ms = '0;
   endfunction

   function automatic logic [15:0] sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void stop_bridge();
      st_duty = '0;
      st_wanted = MODE_STOP;
      if (st_emergency) begin
         st_mode = MODE_EMER;
      end else if (st_mode != MODE_OVER) begin
         st_mode = MODE_STOP;
      end
   endfunction

   function automatic void ask_direction(input logic [2:0] dir, input logic [2:0] opp);
      if (st_wanted == dir) return;
      if (st_mode == MODE_OVER || st_emergency) return;
      if (st_mode == opp) begin
         // reversal: stop now, drive the other way once the dead time has run
         stop_bridge();
         st_dead_wait = 1'b1;
         st_dead_ms = '0;
      end else begin
         st_dead_wait = 1'b0;
      end
      st_wanted = dir;
   endfunction

   function automatic void sample_current(input logic [11:0] s);
      int net_cnt, lhs, rhs;
      if (st_check_ms < CHECK_PERIOD_MS) return;
      st_check_ms = '0;
      net_cnt = (s > cfg.sensor_offset) ? int'(s) - int'(cfg.sensor_offset) : 0;
      if (int'(st_run_ms) < START_WINDOW_MS_DEF) begin
         lhs = net_cnt * 2;
         rhs = int'(cfg.current_limit) * 3;
      end else begin
         lhs = net_cnt;
         rhs = int'(cfg.current_limit);
      end
      if (lhs < rhs) begin
         st_over_on = 1'b0;
         return;
      end
      if (!st_over_on) begin
         st_over_on = 1'b1;
         st_over_ms = '0;
         return;
      end
      if (st_over_ms < cfg.overcurrent_hold_ms) return;
      st_mode = MODE_OVER;
      st_wanted = MODE_STOP;
      st_duty = '0;
      st_led = 1'b1;
      if (!st_window_on || st_window_ms > TRIP_WINDOW_MS) begin
         st_window_on = 1'b1;
         st_window_ms = '0;
         st_trips = 3'd1;
      end else if (st_trips != 3'd7) begin
         st_trips = st_trips + 3'd1;
      end
      if (st_trips > TRIP_LIMIT_DEF) st_hard = 1'b1;
   endfunction

   function automatic void advance_ms(input logic diag, input logic [11:0] s);
      int sum;
      st_dead_ms = sat16(st_dead_ms);
      st_ramp_ms = sat16(st_ramp_ms);
      st_run_ms = sat16(st_run_ms);
      st_check_ms = (st_check_ms == 4'd15) ? st_check_ms : st_check_ms + 4'd1;
      st_over_ms = sat16(st_over_ms);
      st_window_ms = sat16(st_window_ms);

      // the diag line drives the LED while it is lit, so it reads low
      if (st_led) diag = 1'b0;
      if (st_emergency) begin
         if (diag) begin
            st_emergency = 1'b0;
            st_diag_low = '0;
         end else if (st_diag_low == '0) begin
            st_diag_low = 3'd1;
         end else begin
            if (st_diag_low != 3'd7) st_diag_low = st_diag_low + 3'd1;
            if (st_diag_low >= DIAG_CONFIRM_MS && st_mode != MODE_EMER) begin
               st_mode = MODE_EMER;
               return;
            end
         end
      end else begin
         st_diag_low = '0;
      end

      if (st_wanted != MODE_STOP && st_mode != st_wanted) begin
         if (!st_dead_wait || st_dead_ms >= cfg.dead_time_ms) begin
            st_run_ms = '0;
            st_over_on = 1'b0;
            st_mode = st_wanted;
            st_duty = cfg.start_duty;
            st_ramp_ms = '0;
         end
         return;
      end

      if (st_mode == MODE_FWD || st_mode == MODE_REV) begin
         if (st_duty < cfg.run_speed && st_ramp_ms >= cfg.ramp_interval_ms) begin
            st_ramp_ms = '0;
            sum = int'(st_duty) + int'(cfg.ramp_step);
            st_duty = (sum < int'(cfg.run_speed)) ? 8'(sum) : cfg.run_speed;
         end
         sample_current(s);
      end
   endfunction

   function automatic hmpc_rsp_type predict_bridge(input hmpc_req_type w);
      hmpc_rsp_type r;
      logic live;
      if (!w.diag_level && !st_led) begin
         st_emergency = 1'b1;
         st_gated = 1'b1;
      end
      case (w.operation)
         OP_TICK:      advance_ms(w.diag_level, w.current_sample);
         OP_FORWARD:   ask_direction(MODE_FWD, MODE_REV);
         OP_REVERSE:   ask_direction(MODE_REV, MODE_FWD);
         OP_STOP:      stop_bridge();
         OP_CLEAR_OC: begin
            if (!st_hard && !st_emergency && st_mode == MODE_OVER) begin
               st_led = 1'b0;
               st_mode = MODE_STOP;
               st_over_on = 1'b0;
            end
         end
         OP_CLEAR_EMR: begin
            st_led = 1'b0;
            if (w.diag_level && !st_hard) begin
               st_emergency = 1'b0;
               st_gated = 1'b0;
               if (st_mode == MODE_EMER) st_mode = MODE_STOP;
            end
         end
         default: ;
      endcase
      live = (st_mode == MODE_FWD || st_mode == MODE_REV) && !st_gated;
      r.pwm_duty = live ? st_duty : 8'd0;
      r.drive_a = live && st_mode == MODE_FWD;
      r.drive_b = live && st_mode == MODE_REV;
      r.motor_state = st_mode;
      r.fault_led = st_led;
      r.hard_fault = st_hard;
      r.emergency_active = st_emergency;
      return r;
   endfunction

   function automatic hmpc_req_type make_word(input logic [2:0] op, input logic diag,
                                              input logic [11:0] sample);
      hmpc_req_type w;
      w.operation = op;
      w.diag_level = diag;
      w.current_sample = sample;
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 80) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("status word mismatch on %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   task automatic send_word(input hmpc_req_type w);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= w.operation;
      req_ch.diag_level <= w.diag_level;
      req_ch.current_sample <= w.current_sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_status.push_back(predict_bridge(w));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic load_settings(input hmpc_cfg_type c);
      logic [15:0] vals [8];
      wait_idle();
      vals[CSR_RUN_SPEED]     = 16'(c.run_speed);
      vals[CSR_START_DUTY]    = 16'(c.start_duty);
      vals[CSR_RAMP_STEP]     = 16'(c.ramp_step);
      vals[CSR_RAMP_INTERVAL] = c.ramp_interval_ms;
      vals[CSR_DEAD_TIME]     = c.dead_time_ms;
      vals[CSR_SENSOR_OFFSET] = 16'(c.sensor_offset);
      vals[CSR_CURRENT_LIMIT] = 16'(c.current_limit);
      vals[CSR_OC_HOLD]       = c.overcurrent_hold_ms;
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg = c;
   endtask

   // Current samples clustered round the normal and start-window thresholds
   function automatic logic [11:0] pick_sample();
      int t, t15, lo, hi, r;
      t = int'(cfg.sensor_offset) + int'(cfg.current_limit);
      t15 = int'(cfg.sensor_offset) + (3 * int'(cfg.current_limit) + 1) / 2;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         lo = 0;
         hi = t - 1;
      end else if (r < 6) begin
         lo = t - 4;
         hi = t + 4;
      end else if (r < 8) begin
         lo = t15 - 4;
         hi = t15 + 4;
      end else begin
         lo = 0;
         hi = 4095;
      end
      // hold off a fourth trip inside the window, or the bridge latches for good
      if (st_trips >= TRIP_LIMIT_DEF && st_window_on && st_window_ms <= TRIP_WINDOW_MS)
         hi = (hi < t - 1) ? hi : t - 1;
      if (hi > 4095) hi = 4095;
      if (lo < 0) lo = 0;
      if (lo > hi) lo = hi;
      return 12'($urandom_range(hi, lo));
   endfunction

   function automatic hmpc_req_type random_word();
      hmpc_req_type w;
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) w.operation = OP_TICK;
      else if (r < 76) w.operation = OP_FORWARD;
      else if (r < 82) w.operation = OP_REVERSE;
      else if (r < 86) w.operation = OP_STOP;
      else if (r < 90) w.operation = OP_CLEAR_OC;
      else if (r < 95) w.operation = OP_CLEAR_EMR;
      else if (r < 97) w.operation = OP_SPARE_LO;
      else if (r < 98) w.operation = OP_SPARE_HI;
      else w.operation = OP_TICK;
      if (diag_low_left > 0) begin
         w.diag_level = 1'b0;
         diag_low_left--;
      end else begin
         w.diag_level = 1'b1;
         if ($urandom_range(0, 79) == 0) diag_low_left = $urandom_range(1, 12);
      end
      w.current_sample = pick_sample();
      return w;
   endfunction

   function automatic hmpc_cfg_type random_settings();
      hmpc_cfg_type c;
      c.run_speed = 8'($urandom_range(0, 255));
      c.start_duty = 8'($urandom_range(0, 255));
      c.ramp_step = 8'($urandom_range(1, 255));
      c.ramp_interval_ms = 16'($urandom_range(1, 30));
      c.dead_time_ms = 16'($urandom_range(0, 40));
      c.sensor_offset = 12'($urandom_range(0, 600));
      c.current_limit = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                                     : 12'($urandom_range(50, 1500));
      c.overcurrent_hold_ms = 16'($urandom_range(0, 60));
      return c;
   endfunction

   task automatic drive_to_trip();
      int n;
      n = 0;
      send_word(make_word(OP_FORWARD, 1'b1, 12'd0));
      while (st_mode != MODE_OVER && n < 200) begin
         send_word(make_word(OP_TICK, 1'b1, 12'hFFF));
         n++;
      end
      send_word(make_word(OP_CLEAR_OC, 1'b1, 12'd0));
   endtask

   task automatic test_reset_settings();
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
      send_word(make_word(OP_FORWARD, 1'b1, 12'hFFF));
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
      send_word(make_word(OP_STOP, 1'b1, 12'd0));
   endtask

   task automatic test_command_corners();
      load_settings('{run_speed: 8'd255, start_duty: 8'd250, ramp_step: 8'd255,
                      ramp_interval_ms: 16'd1, dead_time_ms: 16'd0,
                      sensor_offset: 12'hFFF, current_limit: 12'hFFF,
                      overcurrent_hold_ms: 16'd0});
      send_word(make_word(OP_SPARE_LO, 1'b1, 12'hFFF));
      send_word(make_word(OP_SPARE_HI, 1'b1, 12'd0));
      send_word(make_word(OP_CLEAR_OC, 1'b1, 12'd0));
      send_word(make_word(OP_FORWARD, 1'b1, 12'd0));
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
      // step overshoots run speed: must saturate
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
      send_word(make_word(OP_REVERSE, 1'b1, 12'd0));
      send_word(make_word(OP_TICK, 1'b1, 12'hFFF));
      // diag low on a command gates at once and blocks the request
      send_word(make_word(OP_FORWARD, 1'b0, 12'd0));
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      repeat (7) send_word(make_word(OP_TICK, 1'b0, 12'hFFF));
      send_word(make_word(OP_CLEAR_EMR, 1'b0, 12'd0));
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      send_word(make_word(OP_STOP, 1'b1, 12'd0));
   endtask

   task automatic test_random_traffic();
      hmpc_cfg_type c;
      for (int p = 0; p < 6; p++) begin
         if (p == 1) begin
            c = '{run_speed: 8'd0, start_duty: 8'd0, ramp_step: 8'd1,
                  ramp_interval_ms: 16'd1, dead_time_ms: 16'd0, sensor_offset: 12'd0,
                  current_limit: 12'd1, overcurrent_hold_ms: 16'd0};
         end else if (p == 2) begin
            c = '{run_speed: 8'd255, start_duty: 8'd255, ramp_step: 8'd255,
                  ramp_interval_ms: 16'hFFFF, dead_time_ms: 16'hFFFF,
                  sensor_offset: 12'hFFF, current_limit: 12'hFFF,
                  overcurrent_hold_ms: 16'hFFFF};
         end else begin
            c = random_settings();
         end
         load_settings(c);
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 250; k++) begin
            if ($urandom_range(0, 299) == 0) wait_idle();
            send_word(random_word());
         end
      end
      quiet = 1'b0;
      diag_low_left = 0;
   endtask

   task automatic test_trip_escalation();
      load_settings('{run_speed: 8'd200, start_duty: 8'd64, ramp_step: 8'd8,
                      ramp_interval_ms: 16'd1, dead_time_ms: 16'd0, sensor_offset: 12'd50,
                      current_limit: 12'd100, overcurrent_hold_ms: 16'd0});
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      send_word(make_word(OP_CLEAR_OC, 1'b1, 12'd0));
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      repeat (4) drive_to_trip();
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      send_word(make_word(OP_FORWARD, 1'b1, 12'd0));
      repeat (8) send_word(make_word(OP_TICK, 1'b0, 12'hFFF));
      send_word(make_word(OP_CLEAR_EMR, 1'b1, 12'd0));
      send_word(make_word(OP_CLEAR_OC, 1'b1, 12'd0));
      send_word(make_word(OP_TICK, 1'b1, 12'd0));
   endtask

   task automatic finish_run();
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("hbridge_motor_protect_controller_top: match");
      end else begin
         $display("hbridge_motor_protect_controller_top: mismatch");
      end
      $finish;
   endtask

   initial begin : status_check
      int stall_left;
      hmpc_rsp_type got, want;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.pwm_duty = rsp_ch.pwm_duty;
            got.drive_a = rsp_ch.drive_a;
            got.drive_b = rsp_ch.drive_b;
            got.motor_state = rsp_ch.motor_state;
            got.fault_led = rsp_ch.fault_led;
            got.hard_fault = rsp_ch.hard_fault;
            got.emergency_active = rsp_ch.emergency_active;
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = expected_status.pop_front();
               if (got.pwm_duty !== want.pwm_duty)
                  report_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
               if (got.drive_a !== want.drive_a)
                  report_mismatch("drive_a", got.drive_a, want.drive_a);
               if (got.drive_b !== want.drive_b)
                  report_mismatch("drive_b", got.drive_b, want.drive_b);
               if (got.motor_state !== want.motor_state)
                  report_mismatch("motor_state", got.motor_state, want.motor_state);
               if (got.fault_led !== want.fault_led)
                  report_mismatch("fault_led", got.fault_led, want.fault_led);
               if (got.hard_fault !== want.hard_fault)
                  report_mismatch("hard_fault", got.hard_fault, want.hard_fault);
               if (got.emergency_active !== want.emergency_active)
                  report_mismatch("emergency_active", got.emergency_active,
                                  want.emergency_active);
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_stall();
         end
      end
   end

   initial begin
      clear_model();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_TICK;
      req_ch.diag_level <= 1'b1;
      req_ch.current_sample <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_RUN_SPEED;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_command_corners();
      test_random_traffic();
      test_trip_escalation();
      finish_run();
   end

endmodule
